// File: src/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg: shared types and constants for the sequenced receive acceptor
// Message kind codes and the fixed field widths of a message header.
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int SEQ_W  = 10;
    localparam int HASH_W = 64;
    localparam int STAMP_W = 64;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_SYNC   = 2'd1,
        KIND_BAD    = 2'd2,
        KIND_STATUS = 2'd3
    } msg_kind_t;

    typedef logic [SEQ_W-1:0]   seq_t;
    typedef logic [HASH_W-1:0]  hash_t;
    typedef logic [STAMP_W-1:0] stamp_t;

endpackage

// File: src/sequenced_receive_acceptor.sv
// ----------------------------------------------------------------------------
// sequenced_receive_acceptor: receive-side decision for a sequenced link
// Takes one received message header per beat and returns one decision:
// deliver, ack, bad-request reply or SYN request, with the echoed fields.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------
//  in      | sink      | in_valid/in_stall| msg_kind seq_num kill_present
//          |           |                  | kill_seq hash_present msg_hash
//          |           |                  | stamp sync_pending
//  out     | source    | out_valid/       | deliver send_ack send_bad_request
//          |           | out_stall        | request_sync reply_seq reply_hash
//          |           |                  | reply_stamp
//
// One beat enters per cycle while in_stall is low; each decision leaves
// through the header register, then the result register. The link state is
// updated in the same cycle the header moves into the result register, so
// back-to-back beats always see the state left by the one before.
// Reset clears the link state and both valid flags; nothing else waits.
// A stall on the output holds the result register and then the header
// register; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
module sequenced_receive_acceptor
    import sra_pkg::*;
#(
    parameter int SEQ_MODULO = 1024
)
(
    input  logic      clk,
    input  logic      rst_n,

    input  logic      in_valid,
    output logic      in_stall,
    input  logic [1:0] msg_kind,
    input  seq_t      seq_num,
    input  logic      kill_present,
    input  seq_t      kill_seq,
    input  logic      hash_present,
    input  hash_t     msg_hash,
    input  stamp_t    stamp,
    input  logic      sync_pending,

    output logic      out_valid,
    input  logic      out_stall,
    output logic      deliver,
    output logic      send_ack,
    output logic      send_bad_request,
    output logic      request_sync,
    output seq_t      reply_seq,
    output hash_t     reply_hash,
    output stamp_t    reply_stamp
);

    // Constant reduction of (seq + 1) mod SEQ_MODULO: reciprocal estimate of
    // the quotient in the header stage, one correcting subtract after.
    localparam int         RECIP_SHIFT = 22;
    localparam int         RECIP_W     = 22;
    localparam int         MOD_W       = 17;
    localparam int         V_W         = SEQ_W + 1;
    localparam int         PROD_W      = V_W + RECIP_W;
    localparam int         REM_W       = V_W + MOD_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SHIFT) / SEQ_MODULO);
    localparam logic [MOD_W-1:0]   MOD_C = MOD_W'(SEQ_MODULO);
    localparam seq_t       SEQ_ALL_ONES = '1;

    // ---------------------------------------------------------------- handshake
    logic   hdr_valid_reg, hdr_valid_next;
    logic   res_valid_reg, res_valid_next;
    logic   in_take;
    logic   hdr_fire;

    assign hdr_fire = hdr_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = hdr_valid_reg && !hdr_fire;
    assign in_take  = in_valid && !in_stall;
    assign out_valid = res_valid_reg;

    always_comb
    begin
        hdr_valid_next = hdr_valid_reg;
        if (in_take)
        begin
            hdr_valid_next = 1'b1;
        end
        else if (hdr_fire)
        begin
            hdr_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (hdr_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            hdr_valid_reg <= hdr_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ---------------------------------------------------------- header register
    msg_kind_t          kind_reg;
    seq_t               seq_reg;
    logic               has_kill_reg;
    seq_t               kill_reg;
    hash_t              hash_reg;
    stamp_t             stamp_reg;
    logic               sync_pending_reg;
    logic [V_W-1:0]     quot_reg;
    // Whether the data message carried a hash; data without one is dropped.
    logic               hash_present_reg;

    logic [V_W-1:0]     in_inc;
    logic [PROD_W-1:0]  in_prod;

    assign in_inc  = V_W'(seq_num) + V_W'(1);
    assign in_prod = PROD_W'(in_inc) * PROD_W'(RECIP);

    // Hash reads as zero when the message carries none.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg         <= msg_kind_t'(msg_kind);
            seq_reg          <= seq_num;
            has_kill_reg     <= kill_present;
            kill_reg         <= kill_seq;
            hash_reg         <= hash_present ? msg_hash : '0;
            stamp_reg        <= stamp;
            sync_pending_reg <= sync_pending;
            quot_reg         <= in_prod[RECIP_SHIFT +: V_W];
            hash_present_reg <= hash_present;
        end
    end

    // --------------------------------------------------------------- link state
    seq_t    expected_seq_reg,  expected_seq_next;
    logic    in_synced_reg,     in_synced_next;
    stamp_t  sync_stamp_reg,    sync_stamp_next;
    logic    sync_stamp_ok_reg, sync_stamp_ok_next;
    seq_t    resync_count_reg,  resync_count_next;
    seq_t    resync_mod_reg,    resync_mod_next;
    hash_t   bad_hash_reg,      bad_hash_next;
    logic    bad_hash_ok_reg,   bad_hash_ok_next;

    // Next sequence after the received one, reduced by the modulus.
    logic [V_W-1:0]    hdr_inc;
    logic [REM_W-1:0]  rem_raw;
    logic [REM_W-1:0]  rem_fix;
    seq_t              seq_after_msg;

    // Next sequence after the expected one; expected stays below the modulus.
    logic [MOD_W-1:0]  exp_inc;
    seq_t              seq_after_exp;

    logic [MOD_W-1:0]  resync_mod_inc;

    assign hdr_inc       = V_W'(seq_reg) + V_W'(1);
    assign rem_raw       = REM_W'(hdr_inc) - (REM_W'(quot_reg) * REM_W'(MOD_C));
    assign rem_fix       = (rem_raw >= REM_W'(MOD_C)) ? (rem_raw - REM_W'(MOD_C)) : rem_raw;
    assign seq_after_msg = rem_fix[SEQ_W-1:0];

    assign exp_inc       = MOD_W'(expected_seq_reg) + MOD_W'(1);
    assign seq_after_exp = (exp_inc == MOD_C) ? '0 : exp_inc[SEQ_W-1:0];

    assign resync_mod_inc = MOD_W'(resync_mod_reg) + MOD_W'(1);

    logic    res_deliver, res_ack, res_bad, res_req;
    seq_t    res_seq;
    hash_t   res_hash;
    stamp_t  res_stamp;

    always_comb
    begin
        expected_seq_next  = expected_seq_reg;
        in_synced_next     = in_synced_reg;
        sync_stamp_next    = sync_stamp_reg;
        sync_stamp_ok_next = sync_stamp_ok_reg;
        resync_count_next  = resync_count_reg;
        resync_mod_next    = resync_mod_reg;
        bad_hash_next      = bad_hash_reg;
        bad_hash_ok_next   = bad_hash_ok_reg;

        res_deliver = 1'b0;
        res_ack     = 1'b0;
        res_bad     = 1'b0;
        res_req     = 1'b0;
        res_seq     = '0;
        res_hash    = '0;
        res_stamp   = '0;

        case (kind_reg)
            KIND_BAD:
            begin
                // Drop while a SYN is already queued; repeat hashes ask once.
                if (!sync_pending_reg && (!bad_hash_ok_reg || bad_hash_reg != hash_reg))
                begin
                    bad_hash_next    = hash_reg;
                    bad_hash_ok_next = 1'b1;
                    res_req          = 1'b1;
                end
            end
            KIND_SYNC:
            begin
                // A sync whose stamp matches the last one is a duplicate.
                if (!(sync_stamp_ok_reg && sync_stamp_reg == stamp_reg))
                begin
                    expected_seq_next  = seq_after_msg;
                    sync_stamp_next    = stamp_reg;
                    sync_stamp_ok_next = 1'b1;
                    resync_count_next  = resync_count_reg + seq_t'(1);
                    if (resync_count_reg == SEQ_ALL_ONES || resync_mod_inc == MOD_C)
                    begin
                        resync_mod_next = '0;
                    end
                    else
                    begin
                        resync_mod_next = resync_mod_inc[SEQ_W-1:0];
                    end
                    in_synced_next     = 1'b1;
                    res_ack            = 1'b1;
                end
            end
            default:
            begin
                if (!in_synced_reg)
                begin
                    res_bad  = 1'b1;
                    res_seq  = resync_mod_reg;
                    res_hash = hash_reg;
                end
                else if (kind_reg == KIND_DATA && hash_present_reg)
                begin
                    if (seq_reg == expected_seq_reg)
                    begin
                        expected_seq_next = seq_after_exp;
                        res_deliver       = 1'b1;
                    end
                    else if (has_kill_reg && kill_reg < expected_seq_reg
                             && seq_reg > expected_seq_reg)
                    begin
                        // Sender gave up on the gap: skip past it.
                        expected_seq_next = seq_after_msg;
                        res_deliver       = 1'b1;
                    end
                    res_ack = 1'b1;
                end
            end
        endcase

        if (res_ack)
        begin
            res_seq   = seq_reg;
            res_hash  = hash_reg;
            res_stamp = stamp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_seq_reg  <= '0;
            in_synced_reg     <= 1'b0;
            sync_stamp_reg    <= '0;
            sync_stamp_ok_reg <= 1'b0;
            resync_count_reg  <= '0;
            resync_mod_reg    <= '0;
            bad_hash_reg      <= '0;
            bad_hash_ok_reg   <= 1'b0;
        end
        else if (hdr_fire)
        begin
            expected_seq_reg  <= expected_seq_next;
            in_synced_reg     <= in_synced_next;
            sync_stamp_reg    <= sync_stamp_next;
            sync_stamp_ok_reg <= sync_stamp_ok_next;
            resync_count_reg  <= resync_count_next;
            resync_mod_reg    <= resync_mod_next;
            bad_hash_reg      <= bad_hash_next;
            bad_hash_ok_reg   <= bad_hash_ok_next;
        end
    end

    // ---------------------------------------------------------- result register
    always_ff @(posedge clk)
    begin
        if (hdr_fire)
        begin
            deliver          <= res_deliver;
            send_ack         <= res_ack;
            send_bad_request <= res_bad;
            request_sync     <= res_req;
            reply_seq        <= res_seq;
            reply_hash       <= res_hash;
            reply_stamp      <= res_stamp;
        end
    end

endmodule
